// File: hdl/ssaa_pkg.sv
// Shared types, constants and functions for the 2x2 supersample downsampler.
package ssaa_pkg;

    localparam int MAX_OUT_WIDTH_DEF = 1024;

    localparam int COLOR_W  = 8;
    localparam int PAIR_W   = COLOR_W + 1;
    localparam int DEPTH_W  = 32;
    localparam int CFG_W    = 11;
    localparam int CFG_H    = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_W-1:0] OUT_WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_H-1:0] OUT_HEIGHT_RESET = CFG_H'(480);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_HEIGHT = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [COLOR_W-1:0] sample_red;
        logic [COLOR_W-1:0] sample_green;
        logic [COLOR_W-1:0] sample_blue;
        logic [DEPTH_W-1:0] sample_depth;
    } t_sample;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [DEPTH_W-1:0] out_depth;
        logic               row_end;
        logic               frame_end;
    } t_result;

    // One line store entry: horizontal pair sums and the pair minimum depth.
    typedef struct packed {
        logic [PAIR_W-1:0]  red_sum;
        logic [PAIR_W-1:0]  green_sum;
        logic [PAIR_W-1:0]  blue_sum;
        logic [DEPTH_W-1:0] depth_min;
    } t_pair;

    localparam int PAIR_ENTRY_W = $bits(t_pair);

    // Position flags from the raster counter.
    typedef struct packed {
        logic col_phase;
        logic row_phase;
        logic last_col;
        logic last_row;
    } t_pos;

endpackage

// File: hdl/ssaa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ssaa_pos.sv
// Raster position counter: output column and row plus the phase within a 2x2 block.
module ssaa_pos
    import ssaa_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = MAX_OUT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_restart,
    input  logic [CFG_W-1:0]     i_out_width,
    input  logic [CFG_H-1:0]     i_out_height,
    output logic [((MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1)-1:0] o_col,
    output t_pos                 o_pos
);

    localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

    logic [AW-1:0]    r_col,  n_col;
    logic [CFG_H-1:0] r_row,  n_row;
    logic             r_col_phase, n_col_phase;
    logic             r_row_phase, n_row_phase;
    logic [CFG_W-1:0] w_last;
    logic [CFG_H-1:0] h_last;
    logic             last_col;
    logic             last_row;

    // Zero width or height counts as one; width saturates at the line store size.
    always_comb begin
        if (i_out_width == '0) begin
            w_last = '0;
        end else if (32'(i_out_width) > 32'(MAX_OUT_WIDTH)) begin
            w_last = CFG_W'(MAX_OUT_WIDTH - 1);
        end else begin
            w_last = i_out_width - CFG_W'(1);
        end
        h_last = (i_out_height == '0) ? '0 : (i_out_height - CFG_H'(1));
    end

    assign last_col = (32'(r_col) == 32'(w_last));
    assign last_row = (r_row == h_last);

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        if (i_restart) begin
            n_col       = '0;
            n_row       = '0;
            n_col_phase = 1'b0;
            n_row_phase = 1'b0;
        end else if (i_advance) begin
            if (!r_col_phase) begin
                n_col_phase = 1'b1;
            end else begin
                n_col_phase = 1'b0;
                if (!last_col) begin
                    n_col = r_col + AW'(1);
                end else begin
                    n_col = '0;
                    if (!r_row_phase) begin
                        n_row_phase = 1'b1;
                    end else begin
                        n_row_phase = 1'b0;
                        n_row       = last_row ? '0 : (r_row + CFG_H'(1));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_col_phase <= 1'b0;
            r_row_phase <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
        end
    end

    assign o_col           = r_col;
    assign o_pos.col_phase = r_col_phase;
    assign o_pos.row_phase = r_row_phase;
    assign o_pos.last_col  = last_col;
    assign o_pos.last_row  = last_row;

endmodule

// File: hdl/ssaa_merge.sv
// Pair and block arithmetic: color sums, rounded averages and IEEE-754 depth minimum.
module ssaa_merge
    import ssaa_pkg::*;
(
    input  t_sample             i_sample,
    input  t_sample             i_held,
    input  t_pair               i_pair,
    output t_pair               o_pair,
    output logic [COLOR_W-1:0]  o_red,
    output logic [COLOR_W-1:0]  o_green,
    output logic [COLOR_W-1:0]  o_blue,
    output logic [DEPTH_W-1:0]  o_depth
);

    localparam int SUM_W = COLOR_W + 2;

    // True when a < b as single-precision values; NaN never compares less and
    // the two zeros compare equal.
    function automatic logic float_less(input logic [DEPTH_W-1:0] a,
                                        input logic [DEPTH_W-1:0] b);
        logic        nan_a;
        logic        nan_b;
        logic [30:0] ma;
        logic [30:0] mb;
        logic        res;
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        ma    = a[30:0];
        mb    = b[30:0];
        if (nan_a || nan_b) begin
            res = 1'b0;
        end else if (ma == '0 && mb == '0) begin
            res = 1'b0;
        end else if (a[31] != b[31]) begin
            res = a[31];
        end else if (!a[31]) begin
            res = (ma < mb);
        end else begin
            res = (ma > mb);
        end
        return res;
    endfunction

    logic [SUM_W-1:0]   sum_red;
    logic [SUM_W-1:0]   sum_green;
    logic [SUM_W-1:0]   sum_blue;
    logic [DEPTH_W-1:0] dmin_upper;

    // Even row: combine the held left sample with the incoming right sample.
    assign o_pair.red_sum   = PAIR_W'(i_held.sample_red)   + PAIR_W'(i_sample.sample_red);
    assign o_pair.green_sum = PAIR_W'(i_held.sample_green) + PAIR_W'(i_sample.sample_green);
    assign o_pair.blue_sum  = PAIR_W'(i_held.sample_blue)  + PAIR_W'(i_sample.sample_blue);
    assign o_pair.depth_min = float_less(i_sample.sample_depth, i_held.sample_depth)
                            ? i_sample.sample_depth : i_held.sample_depth;

    // Odd row: finish the block from the stored pair and the lower pair.
    assign sum_red   = SUM_W'(i_pair.red_sum) + SUM_W'(i_held.sample_red)
                     + SUM_W'(i_sample.sample_red) + SUM_W'(2);
    assign sum_green = SUM_W'(i_pair.green_sum) + SUM_W'(i_held.sample_green)
                     + SUM_W'(i_sample.sample_green) + SUM_W'(2);
    assign sum_blue  = SUM_W'(i_pair.blue_sum) + SUM_W'(i_held.sample_blue)
                     + SUM_W'(i_sample.sample_blue) + SUM_W'(2);

    assign o_red   = sum_red[SUM_W-1:2];
    assign o_green = sum_green[SUM_W-1:2];
    assign o_blue  = sum_blue[SUM_W-1:2];

    assign dmin_upper = float_less(i_held.sample_depth, i_pair.depth_min)
                      ? i_held.sample_depth : i_pair.depth_min;
    assign o_depth    = float_less(i_sample.sample_depth, dmin_upper)
                      ? i_sample.sample_depth : dmin_upper;

endmodule

// File: hdl/ssaa_downsample_2x2.sv
// Top level of the 2x2 box-filter downsampler for a supersampled raster stream.
// Throughput: one input sample per clock while the output is not stalling; a result appears for every fourth sample.
// Latency: a result is valid on the cycle after its bottom-right sample transfer.
// Reset (synchronous, active low) clears position counters, output valid and the
// size registers to 640 x 480; the line store and held sample are not cleared.
module ssaa_downsample_2x2
    import ssaa_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = MAX_OUT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input sample channel.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_sample                i_sample,
    // Result channel.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_result                o_result,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

    logic [CFG_W-1:0]   r_out_width;
    logic [CFG_H-1:0]   r_out_height;
    t_sample            r_held;
    t_result            r_result;
    logic               r_out_valid;

    logic               in_xfer;
    logic               cfg_xfer;
    logic               cfg_restart;
    logic [AW-1:0]      col;
    t_pos               pos;
    logic               ram_we;
    logic               ram_re;
    t_pair              pair_wr;
    logic [PAIR_ENTRY_W-1:0] pair_rd_bits;
    t_pair              pair_rd;
    logic [COLOR_W-1:0] blk_red;
    logic [COLOR_W-1:0] blk_green;
    logic [COLOR_W-1:0] blk_blue;
    logic [DEPTH_W-1:0] blk_depth;
    logic               blk_done;

    // The result register is the only buffer. The input side is held off only
    // while a finished result is waiting and the consumer is stalling, so a
    // new sample is taken in the same cycle that the old result leaves.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_xfer     = i_in_valid & ~o_in_stall;

    // Configuration writes are always taken. A write to a known register
    // restarts the frame; writes beyond the register list are dropped.
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;
    assign cfg_restart = cfg_xfer &
                         ((i_cfg_index == CFG_OUT_WIDTH) || (i_cfg_index == CFG_OUT_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= OUT_WIDTH_RESET;
            r_out_height <= OUT_HEIGHT_RESET;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data[CFG_W-1:0];
                CFG_OUT_HEIGHT: r_out_height <= i_cfg_data[CFG_H-1:0];
                default: begin
                end
            endcase
        end
    end

    ssaa_pos #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (in_xfer),
        .i_restart    (cfg_restart),
        .i_out_width  (r_out_width),
        .i_out_height (r_out_height),
        .o_col        (col),
        .o_pos        (pos)
    );

    // The left sample of every pair is parked until its right neighbor arrives.
    always_ff @(posedge i_clk) begin
        if (in_xfer && !pos.col_phase) begin
            r_held <= i_sample;
        end
    end

    // Even rows write the pair result for this column into the line store.
    // On odd rows the entry is read when the left sample transfers, so its
    // registered read data is ready by the time the right sample arrives,
    // at the earliest on the next cycle. No other read happens in between.
    assign ram_we = in_xfer &  pos.col_phase & ~pos.row_phase;
    assign ram_re = in_xfer & ~pos.col_phase &  pos.row_phase;

    ssaa_ram #(
        .WIDTH (PAIR_ENTRY_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (col),
        .i_wdata (pair_wr),
        .i_re    (ram_re),
        .i_raddr (col),
        .o_rdata (pair_rd_bits)
    );

    assign pair_rd = t_pair'(pair_rd_bits);

    ssaa_merge u_merge (
        .i_sample (i_sample),
        .i_held   (r_held),
        .i_pair   (pair_rd),
        .o_pair   (pair_wr),
        .o_red    (blk_red),
        .o_green  (blk_green),
        .o_blue   (blk_blue),
        .o_depth  (blk_depth)
    );

    // The bottom-right sample of a block completes it.
    assign blk_done = in_xfer & pos.col_phase & pos.row_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (blk_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_done) begin
            r_result.out_red   <= blk_red;
            r_result.out_green <= blk_green;
            r_result.out_blue  <= blk_blue;
            r_result.out_depth <= blk_depth;
            r_result.row_end   <= pos.last_col;
            r_result.frame_end <= pos.last_col & pos.last_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // The line store is never written and read in the same cycle.
    a_ram_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read in the same cycle");

    // A frame end is always also a row end.
    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.frame_end) |-> r_result.row_end)
        else $error("frame end without row end");

    // A completed block is presented on the next cycle.
    a_block_presented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_done |=> r_out_valid)
        else $error("completed block not presented");

    // A write to a known register restarts at the top-left sample of a block.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_restart |=> (!pos.col_phase && !pos.row_phase))
        else $error("configuration write did not restart the frame");

endmodule
